// ----- design/htw_pkg.sv -----
// Shared types and constants for the tree-walk Huffman decoder.
`timescale 1ns / 1ps
`default_nettype none
package htw_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int BYTE_BITS         = 8;
	localparam int NODE_W            = 18;
	localparam int CNT_W             = 4;

	localparam logic [1:0] CMD_NODE = 2'd0;
	localparam logic [1:0] CMD_SYM  = 2'd1;
	localparam logic [1:0] CMD_DEC  = 2'd2;

	typedef struct packed {
		logic [1:0]          kind;
		logic [7:0]          idx;
		logic [NODE_W-1:0]   node;
		logic [7:0]          sym;
		logic [BYTE_BITS-1:0] data;
		logic [CNT_W-1:0]    cnt;
	} htw_entry_t;

endpackage
`default_nettype wire

// ----- design/htw_front.sv -----
// Request intake: classifies requests and queues the ones with work to do.
`timescale 1ns / 1ps
`default_nettype none
module htw_front #(
	parameter int TABLE_ENTRIES = htw_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [7:0]         entry_index,
	input  wire logic               left_is_leaf,
	input  wire logic [7:0]         left_value,
	input  wire logic               right_is_leaf,
	input  wire logic [7:0]         right_value,
	input  wire logic [7:0]         symbol_byte,
	input  wire logic [7:0]         data_byte,
	input  wire logic [3:0]         bit_count,
	output logic                    q_valid,
	input  wire logic               q_pop,
	output htw_pkg::htw_entry_t     q_entry
);
	import htw_pkg::*;

	htw_entry_t  ent;
	logic        keep;
	logic        in_range;
	logic        push;
	htw_entry_t  q_mem_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  fill_q;

	assign in_range = ({24'd0, entry_index} < TABLE_ENTRIES);

	always_comb begin
		ent.kind = cmd;
		ent.idx  = entry_index;
		ent.node = {left_is_leaf, left_value, right_is_leaf, right_value};
		ent.sym  = symbol_byte;
		ent.data = data_byte;
		ent.cnt  = (bit_count > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS) : bit_count;
		unique case (cmd)
			CMD_NODE: keep = in_range;
			CMD_SYM:  keep = in_range;
			CMD_DEC:  keep = (bit_count != '0);
			default:  keep = 1'b0;
		endcase
	end

	assign req_stall = (fill_q == 2'd2);
	assign push      = req_valid && !req_stall && keep;
	assign q_valid   = (fill_q != 2'd0);
	assign q_entry   = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (q_pop) begin
				rp_q <= !rp_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule
`default_nettype wire

// ----- design/htw_back.sv -----
// Table storage and bit-serial tree walk with the result register.
`timescale 1ns / 1ps
`default_nettype none
module htw_back #(
	parameter int TABLE_ENTRIES = htw_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	output logic                    q_pop,
	input  wire htw_pkg::htw_entry_t q_entry,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [7:0]              symbol_out,
	output logic                    last_of_byte
);
	import htw_pkg::*;

	localparam int DEPTH = (TABLE_ENTRIES > 256) ? 256 : TABLE_ENTRIES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [NODE_W-1:0]    node_mem [DEPTH];
	logic [7:0]           sym_mem  [DEPTH];

	logic [1:0]           state_q;
	logic [7:0]           cur_q;
	logic [7:0]           cur_d;
	logic                 fresh_q;
	logic [BYTE_BITS-1:0] data_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NODE_W-1:0]    nrd_s1;
	logic                 nrd_inr_s1;
	logic [7:0]           srd_s1;
	logic                 srd_inr_s1;
	logic                 sym_v_s1;
	logic [7:0]           hold_q;
	logic                 hold_v_q;
	logic                 o_v_q;
	logic [7:0]           o_sym_q;
	logic                 o_last_q;

	logic                 free;
	logic [NODE_W-1:0]    node_w;
	logic                 bit_now;
	logic                 ch_leaf;
	logic [7:0]           ch_val;
	logic                 step;
	logic                 leaf_step;
	logic                 node_we;
	logic                 sym_we;
	logic                 sym_take;
	logic                 hold_push;
	logic                 fin_push;
	logic [7:0]           sym_now;

	assign free     = !o_v_q || !res_stall;
	assign node_w   = nrd_inr_s1 ? nrd_s1 : '0;
	assign bit_now  = data_q[BYTE_BITS-1];
	assign ch_leaf  = bit_now ? node_w[8] : node_w[17];
	assign ch_val   = bit_now ? node_w[7:0] : node_w[16:9];
	assign step     = free && (state_q == ST_WALK) && fresh_q;
	assign leaf_step = step && ch_leaf;
	assign q_pop    = free && (state_q == ST_IDLE) && q_valid;
	assign node_we  = q_pop && (q_entry.kind == CMD_NODE);
	assign sym_we   = q_pop && (q_entry.kind == CMD_SYM);
	assign cur_d    = step ? (ch_leaf ? 8'd0 : ch_val) : cur_q;
	assign sym_now  = srd_inr_s1 ? srd_s1 : 8'd0;
	assign sym_take = free && sym_v_s1;
	assign hold_push = sym_take && hold_v_q;
	assign fin_push = free && (state_q == ST_DRAIN) && !sym_v_s1 && hold_v_q;

	assign res_valid    = o_v_q;
	assign symbol_out   = o_sym_q;
	assign last_of_byte = o_last_q;

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[q_entry.idx[AW-1:0]] <= q_entry.node;
		end
		nrd_s1     <= node_mem[cur_d[AW-1:0]];
		nrd_inr_s1 <= ({24'd0, cur_d} < TABLE_ENTRIES);
	end

	always_ff @(posedge clk) begin
		if (sym_we) begin
			sym_mem[q_entry.idx[AW-1:0]] <= q_entry.sym;
		end
		if (free) begin
			srd_s1     <= sym_mem[ch_val[AW-1:0]];
			srd_inr_s1 <= ({24'd0, ch_val} < TABLE_ENTRIES);
		end
	end

	always_ff @(posedge clk) begin
		if (sym_take) begin
			hold_q <= sym_now;
		end
		if (hold_push || fin_push) begin
			o_sym_q  <= hold_q;
			o_last_q <= fin_push;
		end
		if (q_pop && (q_entry.kind == CMD_DEC)) begin
			data_q <= q_entry.data;
		end else if (step) begin
			data_q <= {data_q[BYTE_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cur_q    <= 8'd0;
			fresh_q  <= 1'b0;
			cnt_q    <= '0;
			sym_v_s1 <= 1'b0;
			hold_v_q <= 1'b0;
			o_v_q    <= 1'b0;
		end else begin
			fresh_q <= !node_we;
			cur_q   <= cur_d;
			if (free) begin
				sym_v_s1 <= leaf_step;
			end
			if (sym_take) begin
				hold_v_q <= 1'b1;
			end else if (fin_push) begin
				hold_v_q <= 1'b0;
			end
			if (hold_push || fin_push) begin
				o_v_q <= 1'b1;
			end else if (!res_stall) begin
				o_v_q <= 1'b0;
			end
			if (free) begin
				unique case (state_q)
					ST_IDLE: begin
						if (q_pop && (q_entry.kind == CMD_DEC)) begin
							cnt_q   <= q_entry.cnt;
							state_q <= ST_WALK;
						end
					end
					ST_WALK: begin
						if (step) begin
							cnt_q <= cnt_q - CNT_W'(1);
							if (cnt_q == CNT_W'(1)) begin
								state_q <= ST_DRAIN;
							end
						end
					end
					ST_DRAIN: begin
						if (!sym_v_s1) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/huffman_tree_walk_decoder_unit.sv -----
// Top level of the tree-walk Huffman decoder.
//
// Requests load tree nodes (cmd 0) and symbol entries (cmd 1) or decode one
// compressed byte (cmd 2); each one with work to do is taken into a two-entry
// queue, so intake runs ahead of decoding. A decode pops its request, makes
// one node-table read per bit, since each bit's read address is the child
// returned by the previous read, and then flushes the final symbol. A byte
// whose last bit reaches a leaf also waits for that symbol-table read. Output
// stalls hold the walk. Symbols leave through a registered output; last_of_byte
// marks the final symbol of each byte, and a byte that reaches no leaf yields
// nothing. The tree position carries over from one byte to the next. Tables
// are undefined until loaded; indexes at or above TABLE_ENTRIES are not stored
// and read as zero.
`timescale 1ns / 1ps
`default_nettype none
module huffman_tree_walk_decoder_unit #(
	parameter int TABLE_ENTRIES = htw_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire logic [1:0] cmd,
	input  wire logic [7:0] entry_index,
	input  wire logic       left_is_leaf,
	input  wire logic [7:0] left_value,
	input  wire logic       right_is_leaf,
	input  wire logic [7:0] right_value,
	input  wire logic [7:0] symbol_byte,
	input  wire logic [7:0] data_byte,
	input  wire logic [3:0] bit_count,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [7:0]      symbol_out,
	output logic            last_of_byte
);
	import htw_pkg::*;

	logic        q_valid;
	logic        q_pop;
	htw_entry_t  q_entry;

	htw_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.entry_index  (entry_index),
		.left_is_leaf (left_is_leaf),
		.left_value   (left_value),
		.right_is_leaf(right_is_leaf),
		.right_value  (right_value),
		.symbol_byte  (symbol_byte),
		.data_byte    (data_byte),
		.bit_count    (bit_count),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_entry      (q_entry)
	);

	htw_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_entry     (q_entry),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.symbol_out  (symbol_out),
		.last_of_byte(last_of_byte)
	);

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the tree-walk Huffman decoder unit.
`timescale 1ns / 1ps
module testbench;
	import htw_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_REQUESTS = 200;
	localparam int FLOOD_REQUESTS = 40;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic [7:0] sym;
		logic       last;
	} sym_rec_t;

	typedef struct {
		htw_entry_t rq;
		int         want_n;
		logic [7:0] want_sym;
	} plan_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic [1:0] cmd = CMD_NODE;
	logic [7:0] entry_index = 8'd0;
	logic       left_is_leaf = 1'b0;
	logic [7:0] left_value = 8'd0;
	logic       right_is_leaf = 1'b0;
	logic [7:0] right_value = 8'd0;
	logic [7:0] symbol_byte = 8'd0;
	logic [7:0] data_byte = 8'd0;
	logic [3:0] bit_count = 4'd0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] symbol_out;
	logic       last_of_byte;

	huffman_tree_walk_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.entry_index(entry_index),
		.left_is_leaf(left_is_leaf),
		.left_value(left_value),
		.right_is_leaf(right_is_leaf),
		.right_value(right_value),
		.symbol_byte(symbol_byte),
		.data_byte(data_byte),
		.bit_count(bit_count),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.symbol_out(symbol_out),
		.last_of_byte(last_of_byte)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// decoder image: tree, symbols, walk position
	logic [NODE_W-1:0] tree_node [0:255];
	logic [7:0]        leaf_sym [0:255];
	bit                node_loaded [0:255];
	bit                sym_loaded [0:255];
	logic [7:0]        node_ids [$];
	logic [7:0]        sym_ids [$];
	logic [7:0]        walk_pos = 8'd0;

	sym_rec_t          walk_syms [$];
	sym_rec_t          syms_due [$];
	sym_rec_t          due;

	int  faults = 0;
	int  syms_checked = 0;
	int  decodes_sent = 0;
	int  requests_sent = 0;
	int  cycle_cnt = 0;
	int  burst_left = 0;
	bit  gapless = 1'b0;
	bit  hold_off_wanted = 1'b0;
	bit  hold_off_done = 1'b0;

	// update the image with one accepted request; leave its symbols in walk_syms
	task automatic absorb_request(input htw_entry_t rq);
		logic [3:0]        n_bits;
		logic [NODE_W-1:0] nd;
		logic              bitv;
		logic              leaf;
		logic [7:0]        val;
		walk_syms.delete();
		case (rq.kind)
			CMD_NODE: begin
				tree_node[rq.idx] = rq.node;
				if (!node_loaded[rq.idx]) begin
					node_loaded[rq.idx] = 1'b1;
					node_ids.insert(node_ids.size(), rq.idx);
				end
			end
			CMD_SYM: begin
				leaf_sym[rq.idx] = rq.sym;
				if (!sym_loaded[rq.idx]) begin
					sym_loaded[rq.idx] = 1'b1;
					sym_ids.insert(sym_ids.size(), rq.idx);
				end
			end
			CMD_DEC: begin
				n_bits = (rq.cnt > 4'd8) ? 4'd8 : rq.cnt;
				for (int i = 0; i < n_bits; i++) begin
					bitv = rq.data[7 - i];
					nd = tree_node[walk_pos];
					leaf = bitv ? nd[8] : nd[17];
					val = bitv ? nd[7:0] : nd[16:9];
					if (leaf) begin
						walk_syms.insert(walk_syms.size(), '{leaf_sym[val], 1'b0});
						walk_pos = 8'd0;
					end else begin
						walk_pos = val;
					end
				end
				if (walk_syms.size() > 0)
					walk_syms[walk_syms.size() - 1].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic due_add(input sym_rec_t s);
		syms_due.insert(syms_due.size(), s);
	endtask

	function automatic plan_row_t row(input logic [1:0] kind, input logic [7:0] idx,
			input logic [NODE_W-1:0] node, input logic [7:0] sym, input logic [7:0] data,
			input logic [3:0] cnt, input int want_n = -1, input logic [7:0] want_sym = 8'd0);
		plan_row_t r;
		r.rq = '{kind, idx, node, sym, data, cnt};
		r.want_n = want_n;
		r.want_sym = want_sym;
		return r;
	endfunction

	// children point only at loaded entries, so no walk reads an unloaded one
	function automatic logic [8:0] pick_child();
		if ($urandom_range(0, 99) < 40)
			return {1'b1, sym_ids[$urandom_range(0, sym_ids.size() - 1)]};
		return {1'b0, node_ids[$urandom_range(0, node_ids.size() - 1)]};
	endfunction

	function automatic htw_entry_t pick_request();
		htw_entry_t  rq;
		logic [63:0] rnd;
		int r;
		int c;
		rnd = {$urandom, $urandom};
		rq = rnd[$bits(htw_entry_t)-1:0];
		r = $urandom_range(0, 99);
		if (r < 60) begin
			rq.kind = CMD_DEC;
			c = $urandom_range(0, 99);
			if (c < 6)
				rq.cnt = 4'd0;
			else if (c < 12)
				rq.cnt = 4'($urandom_range(9, 15));
			else if (c < 55)
				rq.cnt = 4'd8;
			else
				rq.cnt = 4'($urandom_range(1, 8));
		end else if (r < 75) begin
			rq.kind = CMD_SYM;
		end else if (r < 93) begin
			rq.kind = CMD_NODE;
			if ($urandom_range(0, 1) == 0)
				rq.idx = node_ids[$urandom_range(0, node_ids.size() - 1)];
			rq.node = {pick_child(), pick_child()};
		end else begin
			rq.kind = CMD_NONE;
		end
		return rq;
	endfunction

	task automatic offer(input htw_entry_t rq);
		if (!gapless && burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		if (burst_left > 0)
			burst_left--;
		cmd <= rq.kind;
		entry_index <= rq.idx;
		{left_is_leaf, left_value, right_is_leaf, right_value} <= rq.node;
		symbol_byte <= rq.sym;
		data_byte <= rq.data;
		bit_count <= rq.cnt;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		requests_sent++;
		if (rq.kind == CMD_DEC)
			decodes_sent++;
	endtask

	plan_row_t  plan [$];
	htw_entry_t rq;
	int         useful;

	task automatic add_row(input plan_row_t r);
		plan.insert(plan.size(), r);
	endtask

	initial begin
		add_row(row(CMD_SYM, 8'd0, 18'd0, 8'h00, 8'h00, 4'd0));
		add_row(row(CMD_SYM, 8'd255, 18'd0, 8'hFF, 8'h00, 4'd0));
		add_row(row(CMD_SYM, 8'd1, 18'd0, 8'hA5, 8'h00, 4'd0));
		add_row(row(CMD_NODE, 8'd255, {1'b1, 8'd255, 1'b1, 8'd0}, 8'h00, 8'h00, 4'd0));
		add_row(row(CMD_NODE, 8'd0, {1'b1, 8'd1, 1'b0, 8'd255}, 8'h00, 8'h00, 4'd0));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'h00, 4'd1, 1, 8'hA5));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'h80, 4'd2, 1, 8'hFF));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'hC0, 4'd2, 1, 8'h00));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'h00, 4'd8, 8, 8'hA5));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'hFF, 4'd8, 4, 8'h00));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'h7F, 4'd1, 1, 8'hA5));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'h80, 4'd1, 0));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'hFF, 4'd0, 0));
		add_row(row(CMD_NONE, 8'hFF, '1, 8'hFF, 8'hFF, 4'hF, 0));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'h00, 4'd1, 1, 8'hFF));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'h80, 4'd1, 0));
		add_row(row(CMD_NODE, 8'd255, {1'b1, 8'd0, 1'b0, 8'd0}, 8'h00, 8'h00, 4'd0));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'h00, 4'd1));
		add_row(row(CMD_SYM, 8'd0, 18'd0, 8'h3C, 8'h00, 4'd0));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'h40, 4'd9));
		add_row(row(CMD_NODE, 8'd128, {1'b0, 8'd0, 1'b1, 8'd255}, 8'h00, 8'h00, 4'd0));
		add_row(row(CMD_NODE, 8'd0, {1'b0, 8'd128, 1'b1, 8'd1}, 8'h00, 8'h00, 4'd0));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'h5A, 4'd8));
		add_row(row(CMD_DEC, 8'd0, 18'd0, 8'h00, 8'h00, 4'd4));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			offer(plan[i].rq);
			absorb_request(plan[i].rq);
			if (plan[i].want_n < 0) begin
				foreach (walk_syms[k])
					due_add(walk_syms[k]);
			end else begin
				for (int k = 0; k < plan[i].want_n; k++)
					due_add('{plan[i].want_sym, k == plan[i].want_n - 1});
			end
		end

		// flood the input while the receiver holds off
		hold_off_wanted = 1'b1;
		useful = 0;
		while (useful < RANDOM_REQUESTS) begin
			gapless = (useful < FLOOD_REQUESTS);
			rq = pick_request();
			offer(rq);
			absorb_request(rq);
			foreach (walk_syms[k])
				due_add(walk_syms[k]);
			if (rq.kind != CMD_NONE && !(rq.kind == CMD_DEC && rq.cnt == 4'd0))
				useful++;
		end
		req_valid <= 1'b0;

		while (syms_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d requests (%0d decodes) over a loaded tree of %0d nodes",
			requests_sent, decodes_sent, node_ids.size());
		$display("checked %0d decoded symbols, %0d mismatches", syms_checked, faults);
		if (faults == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	int stall_mode;
	int stall_span;

	initial begin
		@(posedge arst_n);
		forever begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(20, 150);
			repeat (stall_span) begin
				@(posedge clk);
				if (hold_off_wanted && !hold_off_done) begin
					hold_off_done = 1'b1;
					res_stall <= 1'b1;
					repeat (HOLD_OFF_CYCLES) @(posedge clk);
				end
				case (stall_mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 3) == 0);
					2: res_stall <= ($urandom_range(0, 3) != 0);
					default: res_stall <= ~res_stall;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (syms_due.size() == 0) begin
				$error("unexpected symbol_out %h last_of_byte %b", symbol_out, last_of_byte);
				faults++;
			end else begin
				due = syms_due.pop_front();
				if (symbol_out !== due.sym) begin
					$error("symbol_out: expected %h, got %h", due.sym, symbol_out);
					faults++;
				end
				if (last_of_byte !== due.last) begin
					$error("last_of_byte: expected %b, got %b", due.last, last_of_byte);
					faults++;
				end
				syms_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

endmodule
